// File: design/vidd_pkg.sv
`default_nettype none

package vidd_pkg;

   localparam int VIDD_STORE_ENTRIES = 4096;
   localparam int VIDD_INDEX_BITS    = 16;

   // Field positions of the packed index triple inside the hashed key.
   localparam int VIDD_POS_SHIFT = 40;
   localparam int VIDD_UV_SHIFT  = 20;

   // Multiplicative hash and its fold.
   localparam logic [63:0] VIDD_HASH_MULT = 64'h9E37_79B9_7F4A_7C15;
   localparam int          VIDD_MIX_SHIFT = 29;

   // Remainder of the hash by a table size that is not a power of two:
   // folds of the upper half on the multiplier, then a reciprocal multiply,
   // a back-multiply and one compare and subtract.
   localparam int VIDD_FOLD_STEPS = 4;
   localparam int VIDD_MOD_STEPS  = VIDD_FOLD_STEPS + 3;

   localparam int VIDD_NUM_W = 16;

   localparam logic VIDD_MODE_CORNER = 1'b0;
   localparam logic VIDD_MODE_CLEAR  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_HASH,
      ST_MIX,
      ST_MOD,
      ST_READ,
      ST_PROBE,
      ST_DONE
   } vidd_state_type;

endpackage

`default_nettype wire

// File: design/vidd_if.sv
`default_nettype none

interface vidd_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [15:0] position_index;
   logic [15:0] uv_index;
   logic [15:0] normal_index;

   modport source (output valid, mode, position_index, uv_index, normal_index,
                   input ready);
   modport sink   (input valid, mode, position_index, uv_index, normal_index,
                   output ready);
endinterface

interface vidd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] vertex_number;
   logic        new_vertex;
   logic        skipped;
   logic        store_full;
   logic [15:0] index_count;

   modport source (output valid, vertex_number, new_vertex, skipped, store_full,
                   index_count, input ready);
   modport sink   (input valid, vertex_number, new_vertex, skipped, store_full,
                   index_count, output ready);
endinterface

interface vidd_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] position_count;

   modport source (output valid, position_count, input ready);
   modport sink   (input valid, position_count, output ready);
endinterface

`default_nettype wire

// File: design/vertex_index_dedup.sv
// Vertex deduplication for indexed mesh building. Each request transfer is
// either a clear command or one face corner (position, UV and normal index).
// A corner whose position index is not below the configured position count
// is reported as skipped; any other corner's index triple is looked up in an
// open-addressed hash table held in a simple dual-port synchronous RAM (one
// read and one write port) with linear probing, returning either the stored
// vertex number or a freshly assigned one (new_vertex set), or store_full
// when every entry is taken. Exactly one response transfer follows each
// request. A corner passes through an accept step, multiplicative hashing
// on a shared 32x32 multiplier, a fold step, (when STORE_ENTRIES is not a
// power of two) remainder reduction on the same multiplier, a RAM read, a
// probe of each entry in turn and the load of the response register; up to
// STORE_ENTRIES entries are probed when the table is full. A skipped corner
// goes from the accept step straight to the response load. The table is
// cleared by a pass that writes one entry per cycle, and after reset the
// block holds req_if.ready low while that pass runs. The position_count
// register may be written at any time the block is idle; csr_if.ready is
// always high.

`default_nettype none

module vertex_index_dedup #(
   parameter int STORE_ENTRIES = vidd_pkg::VIDD_STORE_ENTRIES,
   parameter int INDEX_BITS    = vidd_pkg::VIDD_INDEX_BITS
) (
   input  wire logic clock,
   input  wire logic reset,
   vidd_req_if.sink   req_if,
   vidd_rsp_if.source rsp_if,
   vidd_csr_if.sink   csr_if
);
   import vidd_pkg::*;

   localparam int  SLOT_W   = $clog2(STORE_ENTRIES);
   localparam int  PROBE_W  = $clog2(STORE_ENTRIES + 1);
   localparam int  KEY_W    = 3 * INDEX_BITS;
   localparam int  ENTRY_W  = 1 + VIDD_NUM_W + KEY_W;
   localparam bit  IS_POW2  = (STORE_ENTRIES & (STORE_ENTRIES - 1)) == 0;
   localparam int  STEP_W   = $clog2(VIDD_MOD_STEPS);

   localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(STORE_ENTRIES - 1);
   localparam logic [PROBE_W-1:0] LAST_PROBE = PROBE_W'(STORE_ENTRIES - 1);
   localparam logic [31:0]        MODULUS    = 32'(STORE_ENTRIES);
   // 2^32 modulo the table size, and the truncated reciprocal 2^32 / size.
   localparam logic [63:0]        FOLD_MULT  = (64'd1 << 32) % 64'(STORE_ENTRIES);
   localparam logic [63:0]        RECIP      = (64'd1 << 32) / 64'(STORE_ENTRIES);
   localparam logic [STEP_W-1:0]  LAST_FOLD  = STEP_W'(VIDD_FOLD_STEPS - 1);
   localparam logic [STEP_W-1:0]  QUOT_STEP  = STEP_W'(VIDD_FOLD_STEPS);
   localparam logic [STEP_W-1:0]  SUB_STEP   = STEP_W'(VIDD_FOLD_STEPS + 1);
   localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(VIDD_MOD_STEPS - 1);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   vidd_state_type state_ff, state_in;

   logic [15:0]          pcount_ff,  pcount_in;
   logic [15:0]          vcnt_ff,    vcnt_in;    // next vertex number
   logic [15:0]          ecnt_ff,    ecnt_in;    // indices emitted so far
   logic                 pend_clr_ff, pend_clr_in;
   logic [SLOT_W-1:0]    sweep_ff,   sweep_in;
   logic [KEY_W-1:0]     key_ff,     key_in;
   logic [1:0]           mstep_ff,   mstep_in;
   logic [63:0]          acc_ff,     acc_in;
   logic [63:0]          hsh_ff,     hsh_in;
   logic [STEP_W-1:0]    dstep_ff,   dstep_in;
   logic [SLOT_W-1:0]    slot_ff,    slot_in;
   logic [PROBE_W-1:0]   probe_ff,   probe_in;

   // Result of the item under work, before it moves to the response register.
   logic [15:0]          res_vnum_ff, res_vnum_in;
   logic                 res_new_ff,  res_new_in;
   logic                 res_skip_ff, res_skip_in;
   logic                 res_full_ff, res_full_in;

   // Response register: it lets the next request be accepted while a
   // finished result still waits for its transfer.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_vnum_ff,  rsp_vnum_in;
   logic                 rsp_new_ff,   rsp_new_in;
   logic                 rsp_skip_ff,  rsp_skip_in;
   logic                 rsp_full_ff,  rsp_full_in;
   logic [15:0]          rsp_icnt_ff,  rsp_icnt_in;

   // ---------------------------------------------------------------------
   // Hash table RAM: {valid, vertex number, packed key} per entry.
   // ---------------------------------------------------------------------
   logic [ENTRY_W-1:0]   mem [STORE_ENTRIES];
   logic [ENTRY_W-1:0]   rd_data_ff;
   logic [SLOT_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [SLOT_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]   wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // ---------------------------------------------------------------------
   // Combinational helpers
   // ---------------------------------------------------------------------
   logic                 req_fire;
   logic                 rsp_free;
   logic                 rsp_load;
   logic [KEY_W-1:0]     req_key;
   logic                 req_skip;
   logic [63:0]          key64;
   logic [31:0]          mul_a;
   logic [31:0]          mul_b;
   logic [63:0]          prod;
   logic [63:0]          mixed;
   logic [SLOT_W-1:0]    rem_next;
   logic [SLOT_W-1:0]    slot_inc;
   logic                 ent_valid;
   logic [15:0]          ent_vnum;
   logic [KEY_W-1:0]     ent_key;
   logic                 ent_hit;
   logic                 ent_free;
   logic                 probe_last;

   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   // Indices are cut to (or zero-extended to) INDEX_BITS, then packed.
   assign req_key = {INDEX_BITS'(req_if.position_index),
                     INDEX_BITS'(req_if.uv_index),
                     INDEX_BITS'(req_if.normal_index)};
   assign req_skip = req_if.position_index >= pcount_ff;

   // The hashed key spaces the three fields apart at fixed bit positions.
   assign key64 = (64'(key_ff[2*INDEX_BITS +: INDEX_BITS]) << VIDD_POS_SHIFT)
                | (64'(key_ff[INDEX_BITS +: INDEX_BITS])   << VIDD_UV_SHIFT)
                |  64'(key_ff[0 +: INDEX_BITS]);

   // key64 * HASH_MULT modulo 2^64 from three 32x32 partial products on one
   // multiplier: lo*lo, then the low halves of both cross products. During
   // the remainder reduction the same multiplier serves the folds, the
   // reciprocal multiply and the back-multiply.
   always_comb begin
      mul_a = key64[31:0];
      mul_b = VIDD_HASH_MULT[31:0];
      if (state_ff == ST_MOD) begin
         if (dstep_ff <= LAST_FOLD) begin
            mul_a = hsh_ff[63:32];
            mul_b = FOLD_MULT[31:0];
         end else if (dstep_ff == QUOT_STEP) begin
            mul_a = hsh_ff[31:0];
            mul_b = RECIP[31:0];
         end else begin
            mul_a = acc_ff[63:32];
            mul_b = MODULUS;
         end
      end else begin
         unique case (mstep_ff)
            2'd0: begin
               mul_a = key64[31:0];
               mul_b = VIDD_HASH_MULT[31:0];
            end
            2'd1: begin
               mul_a = key64[31:0];
               mul_b = VIDD_HASH_MULT[63:32];
            end
            default: begin
               mul_a = key64[63:32];
               mul_b = VIDD_HASH_MULT[31:0];
            end
         endcase
      end
   end

   assign prod  = 64'(mul_a) * 64'(mul_b);
   assign mixed = acc_ff ^ (acc_ff >> VIDD_MIX_SHIFT);

   // Each fold replaces hi * 2^32 + lo by hi * (2^32 mod size) + lo, which
   // keeps the value modulo the table size; four folds bring it below 2^32.
   // The reciprocal quotient is at most one short, so after the
   // back-multiply the partial remainder is below twice the table size and
   // one compare and subtract finishes it.
   assign rem_next = (hsh_ff[31:0] >= MODULUS) ? SLOT_W'(hsh_ff[31:0] - MODULUS)
                                               : hsh_ff[SLOT_W-1:0];

   assign slot_inc = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;

   assign ent_valid  = rd_data_ff[ENTRY_W-1];
   assign ent_vnum   = rd_data_ff[KEY_W +: VIDD_NUM_W];
   assign ent_key    = rd_data_ff[KEY_W-1:0];
   assign ent_hit    = ent_valid && (ent_key == key_ff);
   // Entries are only ever added between clears, so the first empty entry
   // on the probe path ends the search and is where a new key goes.
   assign ent_free   = !ent_valid;
   assign probe_last = probe_ff == LAST_PROBE;

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_if.mode == VIDD_MODE_CLEAR) begin
                  state_in = ST_SWEEP;
               end else if (req_skip) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_SWEEP: begin
            if (sweep_ff == LAST_SLOT) begin
               state_in = pend_clr_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_HASH: begin
            if (mstep_ff == 2'd2) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            state_in = IS_POW2 ? ST_READ : ST_MOD;
         end
         ST_MOD: begin
            if (dstep_ff == LAST_STEP) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (ent_hit || ent_free || probe_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Control outputs: handshake, RAM ports, response load
   // ---------------------------------------------------------------------
   always_comb begin
      req_if.ready = 1'b0;
      rd_addr      = slot_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = {1'b1, vcnt_ff, key_ff};
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
         end
         ST_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
            wr_data = '0;
         end
         ST_PROBE: begin
            // Read the next entry ahead so a collision needs no separate read state.
            rd_addr = slot_inc;
            wr_en   = ent_free && !ent_hit;
         end
         ST_DONE: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   assign csr_if.ready = 1'b1;

   // ---------------------------------------------------------------------
   // Datapath next values
   // ---------------------------------------------------------------------
   always_comb begin
      pcount_in   = pcount_ff;
      vcnt_in     = vcnt_ff;
      ecnt_in     = ecnt_ff;
      pend_clr_in = pend_clr_ff;
      sweep_in    = sweep_ff;
      key_in      = key_ff;
      mstep_in    = mstep_ff;
      acc_in      = acc_ff;
      hsh_in      = hsh_ff;
      dstep_in    = dstep_ff;
      slot_in     = slot_ff;
      probe_in    = probe_ff;
      res_vnum_in = res_vnum_ff;
      res_new_in  = res_new_ff;
      res_skip_in = res_skip_ff;
      res_full_in = res_full_ff;

      if (csr_if.valid && csr_if.ready) begin
         pcount_in = csr_if.position_count;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_vnum_in = '0;
               res_new_in  = 1'b0;
               res_full_in = 1'b0;
               res_skip_in = 1'b0;
               key_in      = req_key;
               mstep_in    = 2'd0;
               if (req_if.mode == VIDD_MODE_CLEAR) begin
                  pend_clr_in = 1'b1;
                  sweep_in    = '0;
                  vcnt_in     = '0;
                  ecnt_in     = '0;
               end else begin
                  res_skip_in = req_skip;
               end
            end
         end
         ST_SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
         end
         ST_HASH: begin
            mstep_in = mstep_ff + 2'd1;
            if (mstep_ff == 2'd0) begin
               acc_in = prod;
            end else begin
               acc_in = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
            end
         end
         ST_MIX: begin
            slot_in  = mixed[SLOT_W-1:0];
            hsh_in   = mixed;
            dstep_in = '0;
            probe_in = '0;
         end
         ST_MOD: begin
            dstep_in = dstep_ff + 1'b1;
            if (dstep_ff <= LAST_FOLD) begin
               hsh_in = prod + {32'd0, hsh_ff[31:0]};
            end else if (dstep_ff == QUOT_STEP) begin
               acc_in = prod;
            end else if (dstep_ff == SUB_STEP) begin
               hsh_in = {32'd0, hsh_ff[31:0] - prod[31:0]};
            end else begin
               slot_in = rem_next;
            end
         end
         ST_PROBE: begin
            if (ent_hit) begin
               res_vnum_in = ent_vnum;
               ecnt_in     = ecnt_ff + 16'd1;
            end else if (ent_free) begin
               res_vnum_in = vcnt_ff;
               res_new_in  = 1'b1;
               vcnt_in     = vcnt_ff + 16'd1;
               ecnt_in     = ecnt_ff + 16'd1;
            end else if (probe_last) begin
               res_full_in = 1'b1;
            end else begin
               slot_in  = slot_inc;
               probe_in = probe_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               pend_clr_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Response register: loaded from the finished item, held until taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_vnum_in  = rsp_vnum_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_skip_in  = rsp_skip_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_icnt_in  = rsp_icnt_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_vnum_in  = res_vnum_ff;
         rsp_new_in   = res_new_ff;
         rsp_skip_in  = res_skip_ff;
         rsp_full_in  = res_full_ff;
         rsp_icnt_in  = ecnt_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Register updates
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         pcount_ff    <= '0;
         vcnt_ff      <= '0;
         ecnt_ff      <= '0;
         pend_clr_ff  <= 1'b0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pcount_ff    <= pcount_in;
         vcnt_ff      <= vcnt_in;
         ecnt_ff      <= ecnt_in;
         pend_clr_ff  <= pend_clr_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      mstep_ff    <= mstep_in;
      acc_ff      <= acc_in;
      hsh_ff      <= hsh_in;
      dstep_ff    <= dstep_in;
      slot_ff     <= slot_in;
      probe_ff    <= probe_in;
      res_vnum_ff <= res_vnum_in;
      res_new_ff  <= res_new_in;
      res_skip_ff <= res_skip_in;
      res_full_ff <= res_full_in;
      rsp_vnum_ff <= rsp_vnum_in;
      rsp_new_ff  <= rsp_new_in;
      rsp_skip_ff <= rsp_skip_in;
      rsp_full_ff <= rsp_full_in;
      rsp_icnt_ff <= rsp_icnt_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.vertex_number = rsp_vnum_ff;
   assign rsp_if.new_vertex    = rsp_new_ff;
   assign rsp_if.skipped       = rsp_skip_ff;
   assign rsp_if.store_full    = rsp_full_ff;
   assign rsp_if.index_count   = rsp_icnt_ff;

endmodule

`default_nettype wire

// File: tb/vidd_dedup_checker.sv
module vidd_dedup_checker (
   input  wire logic clock,
   input  wire logic reset,
   vidd_req_if       req_if,
   vidd_rsp_if       rsp_if,
   vidd_csr_if       csr_if,
   output int        mismatch_count,
   output int        pending_count,
   output int        hit_count,
   output int        insert_count,
   output int        skip_count,
   output int        full_count,
   output int        clear_count,
   output int        wrap_count
);
   import vidd_pkg::*;

   typedef struct packed {
      logic [15:0] vertex_number;
      logic        new_vertex;
      logic        skipped;
      logic        store_full;
      logic [15:0] index_count;
   } vertex_result_type;

   // Shadow of the block: the store only has to answer whether a triple was
   // seen, so an associative array keyed by the triple stands in for it.
   logic [15:0]       position_limit;
   logic [15:0]       vertex_by_triple [logic [47:0]];
   logic [15:0]       next_vertex;
   logic [15:0]       emitted_indices;
   vertex_result_type pending_lookups [$];

   function automatic vertex_result_type resolve_corner(input logic op,
                                                        input logic [15:0] pos,
                                                        input logic [15:0] uv,
                                                        input logic [15:0] nrm);
      vertex_result_type outcome;
      logic [47:0]       triple;
      outcome = '0;
      triple  = {pos, uv, nrm};
      if (op == VIDD_MODE_CLEAR) begin
         vertex_by_triple.delete();
         next_vertex     = '0;
         emitted_indices = '0;
         clear_count++;
      end else if (pos >= position_limit) begin
         outcome.skipped = 1'b1;
         skip_count++;
      end else if (vertex_by_triple.exists(triple)) begin
         outcome.vertex_number = vertex_by_triple[triple];
         emitted_indices++;
         hit_count++;
         if (emitted_indices == '0) wrap_count++;
      end else if (vertex_by_triple.num() < VIDD_STORE_ENTRIES) begin
         vertex_by_triple[triple] = next_vertex;
         outcome.vertex_number    = next_vertex;
         outcome.new_vertex       = 1'b1;
         next_vertex++;
         emitted_indices++;
         insert_count++;
         if (emitted_indices == '0) wrap_count++;
      end else begin
         outcome.store_full = 1'b1;
         full_count++;
      end
      outcome.index_count = emitted_indices;
      return outcome;
   endfunction

   function automatic void log_failure(input string why, input vertex_result_type want,
                                       input vertex_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"%0t %s: expected vertex %0d new %0b skipped %0b full %0b count %0d,",
                   " got vertex %0d new %0b skipped %0b full %0b count %0d"},
                  $time, why, want.vertex_number, want.new_vertex, want.skipped,
                  want.store_full, want.index_count, got.vertex_number, got.new_vertex,
                  got.skipped, got.store_full, got.index_count);
   endfunction

   always @(posedge clock) begin
      vertex_result_type want;
      vertex_result_type got;
      if (reset) begin
         position_limit  = '0;
         next_vertex     = '0;
         emitted_indices = '0;
         vertex_by_triple.delete();
         pending_lookups.delete();
         mismatch_count = 0;
         hit_count      = 0;
         insert_count   = 0;
         skip_count     = 0;
         full_count     = 0;
         clear_count    = 0;
         wrap_count     = 0;
      end else begin
         if (csr_if.valid && csr_if.ready) position_limit = csr_if.position_count;

         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.vertex_number, rsp_if.new_vertex, rsp_if.skipped,
                   rsp_if.store_full, rsp_if.index_count};
            if (pending_lookups.size() == 0) begin
               log_failure("result with no corner outstanding", '0, got);
            end else begin
               want = pending_lookups.pop_front();
               if (got !== want) log_failure("result mismatch", want, got);
            end
         end

         if (req_if.valid && req_if.ready)
            pending_lookups.push_back(resolve_corner(req_if.mode, req_if.position_index,
                                                     req_if.uv_index, req_if.normal_index));
      end
      pending_count = pending_lookups.size();
   end

endmodule

// File: tb/tb.sv
module tb;
   import vidd_pkg::*;

   // A full-table miss or a clear walks every entry, so the quiet stretch
   // allowed between transfers has to cover several of those sweeps.
   localparam int STALL_LIMIT = 20000;

   logic        clock;
   logic        reset;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int          hold_cycles;
   int          quiet_cycles;
   int unsigned positions;

   int mismatch_count;
   int pending_count;
   int hit_count;
   int insert_count;
   int skip_count;
   int full_count;
   int clear_count;
   int wrap_count;

   vidd_req_if req_if ();
   vidd_rsp_if rsp_if ();
   vidd_csr_if csr_if ();

   vertex_index_dedup u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // The checker watches all three channels, keeps its own picture of the
   // store and counters, and compares every response transfer in order.
   vidd_dedup_checker u_dedup_check (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .csr_if         (csr_if),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .hit_count      (hit_count),
      .insert_count   (insert_count),
      .skip_count     (skip_count),
      .full_count     (full_count),
      .clear_count    (clear_count),
      .wrap_count     (wrap_count)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // The watchdog counts cycles with no transfer on any channel. It is the
   // only way the run can end early.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                   (csr_if.valid && csr_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_count);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Response side. Ready is decided once per falling edge: either a long
   // hold-off requested by the stimulus is being counted down, or a random
   // stall at the current idle rate.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Offers one request and returns at the falling edge after its transfer.
   // Valid is assigned at most once per falling edge: either lowered for an
   // idle cycle or raised for the item, so back-to-back items keep it high.
   task automatic offer_corner(input logic op, input logic [15:0] pos, input logic [15:0] uv,
                               input logic [15:0] nrm);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.mode           <= op;
      req_if.position_index <= pos;
      req_if.uv_index       <= uv;
      req_if.normal_index   <= nrm;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stops offering and waits until every outstanding request has its result.
   task automatic wait_results_drained();
      req_if.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // The register is only written with the block idle, so drain first.
   task automatic write_position_count(input logic [15:0] count);
      wait_results_drained();
      csr_if.valid          <= 1'b1;
      csr_if.position_count <= count;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      positions = 32'(count);
   endtask

   // UV and normal indices: mostly absent or from a tiny pool so that
   // triples repeat, sometimes anything at all.
   function automatic logic [15:0] any_attribute();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) return 16'hFFFF;
      if (pick < 8) return 16'($urandom_range(0, 2));
      return 16'($urandom);
   endfunction

   // One random block under a fresh position count. Most items are valid
   // corners drawn from a small pool so that lookups hit often; the rest
   // are out-of-range corners, unrestricted noise and the odd clear.
   task automatic run_random_block(input int count);
      int unsigned pick;
      int unsigned pool;
      logic [15:0] pos;
      pick = $urandom_range(0, 9);
      if (pick == 0) write_position_count(16'h0000);
      else if (pick == 1) write_position_count(16'hFFFF);
      else if (pick < 4) write_position_count(16'($urandom_range(1, 65535)));
      else write_position_count(16'($urandom_range(1, 8)));
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            offer_corner(VIDD_MODE_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
         end else if (pick < 12) begin
            offer_corner(VIDD_MODE_CORNER, 16'($urandom), 16'($urandom), 16'($urandom));
         end else if (pick < 20) begin
            offer_corner(VIDD_MODE_CORNER, 16'($urandom_range(positions, 65535)),
                         any_attribute(), any_attribute());
         end else begin
            if (positions == 0) begin
               pos = 16'($urandom);
            end else if ($urandom_range(0, 99) < 70) begin
               pool = (positions < 4) ? positions : 4;
               pos  = 16'($urandom_range(0, pool - 1));
            end else begin
               pos = 16'($urandom_range(0, positions - 1));
            end
            offer_corner(VIDD_MODE_CORNER, pos, any_attribute(), any_attribute());
         end
      end
   endtask

   initial begin
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.mode           = VIDD_MODE_CORNER;
      req_if.position_index = '0;
      req_if.uv_index       = '0;
      req_if.normal_index   = '0;
      csr_if.valid          = 1'b0;
      csr_if.position_count = '0;
      send_idle_pct         = 30;
      recv_idle_pct         = 51;
      hold_cycles           = 0;
      positions             = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed corners. The first one runs against the reset position
      // count of zero, so even position 0 must come back skipped.
      offer_corner(VIDD_MODE_CORNER, 16'h0000, 16'h0000, 16'h0000);

      write_position_count(16'h8000);
      offer_corner(VIDD_MODE_CORNER, 16'h0000, 16'h0000, 16'h0000);
      // Highest valid position with UV and normal both absent.
      offer_corner(VIDD_MODE_CORNER, 16'h7FFF, 16'hFFFF, 16'hFFFF);
      // Position equal to the count, then the largest position: both dropped.
      offer_corner(VIDD_MODE_CORNER, 16'h8000, 16'h0001, 16'h0001);
      offer_corner(VIDD_MODE_CORNER, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // Repeats of earlier triples must hit and return the same vertex.
      offer_corner(VIDD_MODE_CORNER, 16'h0000, 16'h0000, 16'h0000);
      offer_corner(VIDD_MODE_CORNER, 16'h7FFF, 16'hFFFF, 16'hFFFF);
      // Triples that differ in one field or in every field are distinct vertices.
      offer_corner(VIDD_MODE_CORNER, 16'h7FFF, 16'hFFFF, 16'h0000);
      offer_corner(VIDD_MODE_CORNER, 16'h7FFF, 16'h0000, 16'hFFFF);
      offer_corner(VIDD_MODE_CORNER, 16'h5555, 16'hAAAA, 16'h5555);
      offer_corner(VIDD_MODE_CORNER, 16'h2AAA, 16'h5555, 16'hAAAA);
      // A clear empties the store and restarts both counters, whatever the
      // other fields of the request hold.
      offer_corner(VIDD_MODE_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      offer_corner(VIDD_MODE_CORNER, 16'h7FFF, 16'hFFFF, 16'hFFFF);
      offer_corner(VIDD_MODE_CORNER, 16'h0000, 16'h0000, 16'h0000);

      write_position_count(16'hFFFF);
      offer_corner(VIDD_MODE_CORNER, 16'hFFFF, 16'h0000, 16'h0000);
      offer_corner(VIDD_MODE_CORNER, 16'hFFFE, 16'hFFFF, 16'hFFFF);
      offer_corner(VIDD_MODE_CORNER, 16'hFFFE, 16'hFFFF, 16'hFFFF);
      offer_corner(VIDD_MODE_CORNER, 16'h0000, 16'h0000, 16'h0000);

      write_position_count(16'h0001);
      offer_corner(VIDD_MODE_CORNER, 16'h0000, 16'h0000, 16'h0000);
      offer_corner(VIDD_MODE_CORNER, 16'h0001, 16'h0000, 16'h0000);
      offer_corner(VIDD_MODE_CORNER, 16'h0000, 16'hFFFF, 16'hFFFF);
      offer_corner(VIDD_MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000);

      // Random traffic, first with the sender idling less than the receiver.
      repeat (4) run_random_block(40);

      // Then the other way round.
      send_idle_pct = 51;
      recv_idle_pct = 30;
      repeat (4) run_random_block(40);

      // From here on neither side idles on its own.
      send_idle_pct = 0;
      recv_idle_pct = 0;

      // Back-pressure: the receiver holds off for a long stretch while
      // corners keep coming, so the block fills up and drops its ready.
      // Afterwards the sender pauses until every result is back.
      write_position_count(16'h0008);
      hold_cycles = 300;
      repeat (16)
         offer_corner(VIDD_MODE_CORNER, 16'($urandom_range(0, 7)), any_attribute(),
                      any_attribute());
      wait_results_drained();

      run_random_block(40);

      // Wind down: every result in, then a full table sweep's worth of
      // cycles to catch any response that should not be there.
      wait_results_drained();
      repeat (VIDD_STORE_ENTRIES + 64) @(posedge clock);

      $display("Covered %0d hits, %0d inserts, %0d skipped, %0d store-full and %0d clears",
               hit_count, insert_count, skip_count, full_count, clear_count);
      $display("Index count wrapped %0d time(s); %0d mismatches, %0d results outstanding",
               wrap_count, mismatch_count, pending_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
